### rtl/fti_pkg.sv
// Shared types, constants and constant ROM tables for the foot trajectory interpolator.
// Used by fti_lookup and foot_trajectory_interpolator; depends on nothing else.
package fti_pkg;

	localparam int PHASE_BITS  = 16;
	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);
	localparam int EASE_IDX_W  = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W       = 16 + EASE_IDX_W;
	localparam int SIN_W       = 18;

	localparam int Q16_ONE        = 65536;
	localparam int INV_TWO_PI_Q16 = 10430;
	localparam int GAP_SIDE       = 480;
	localparam int GAP_RISE       = 480;
	localparam int GAP_ARC        = 320;
	localparam int GAP_RISE_END   = 3 * Q16_ONE;
	// floor(10t/3) = (t * 10 * ((2^21 + 1) / 3)) >> 21 for 10t below 2^21
	localparam int GAP_S_MUL      = 10 * 699051;
	// floor(n/7) = (n * ceil(2^22 / 7)) >> 22 for n below 2^19
	localparam int DIV7_MUL       = 599187;

	localparam logic [PHASE_BITS:0] PHASE_ONE = {1'b1, {PHASE_BITS{1'b0}}};
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	localparam logic [2:0] OP_LINEAR    = 3'd0;
	localparam logic [2:0] OP_CYCLOID   = 3'd1;
	localparam logic [2:0] OP_THREE_SEG = 3'd2;
	localparam logic [2:0] OP_PARABOLIC = 3'd3;
	localparam logic [2:0] OP_EASE      = 3'd4;
	localparam logic [2:0] OP_GAP       = 3'd5;

	localparam logic [1:0] SEG_LIFT = 2'd0;
	localparam logic [1:0] SEG_MOVE = 2'd1;
	localparam logic [1:0] SEG_DROP = 2'd2;

	localparam int CFG_ADDR_W = 4;
	localparam logic [1:0] REG_SWING = 2'd0;
	localparam logic [1:0] REG_LIFT  = 2'd1;
	localparam logic [1:0] REG_ARC   = 2'd2;
	localparam logic [11:0] SWING_RESET = 12'd560;
	localparam logic [11:0] LIFT_RESET  = 12'd1280;
	localparam logic [11:0] ARC_RESET   = 12'd800;

	typedef struct packed {
		logic [2:0]          operation;
		logic signed [15:0]  start_x;
		logic signed [15:0]  start_y;
		logic signed [15:0]  start_z;
		logic signed [15:0]  target_x;
		logic signed [15:0]  target_y;
		logic signed [15:0]  target_z;
		logic [PHASE_BITS:0] phase;
	} req_t;

	typedef struct packed {
		logic signed [15:0] foot_x;
		logic signed [15:0] foot_y;
		logic signed [15:0] foot_z;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] sz;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
	} pts_t;

	typedef logic signed [SIN_W-1:0] sin_rom_t [TABLE_DEPTH];
	typedef logic signed [SIN_W-1:0] ease_rom_t [TABLE_DEPTH+1];

	localparam logic [63:0] ONE30       = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// sin(pi/2 * r / D) in Q16, Taylor series in Q30
	function automatic logic [63:0] quarter_sine(input logic [63:0] r);
		logic [63:0] x, x2, p;
		x  = (HALF_PI_Q30 * r + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
		x2 = (x * x + (64'd1 << 29)) >> 30;
		p  = ONE30;
		p  = ONE30 - ((x2 * p) >> 30) / 64'd110;
		p  = ONE30 - ((x2 * p) >> 30) / 64'd72;
		p  = ONE30 - ((x2 * p) >> 30) / 64'd42;
		p  = ONE30 - ((x2 * p) >> 30) / 64'd20;
		p  = ONE30 - ((x2 * p) >> 30) / 64'd6;
		return (x * p + (64'd1 << 43)) >> 44;
	endfunction

	// exp(-5k/D) in Q30: series for exp(-z) with z = 5k/(8D), then squared three times
	function automatic logic [63:0] neg_exp_q30(input logic [63:0] k);
		logic [63:0] z, p;
		z = (64'd5 * ONE30 * k + 64'(4 * TABLE_DEPTH)) / 64'(8 * TABLE_DEPTH);
		p = ONE30;
		p = ONE30 - ((z * p) >> 30) / 64'd14;
		p = ONE30 - ((z * p) >> 30) / 64'd13;
		p = ONE30 - ((z * p) >> 30) / 64'd12;
		p = ONE30 - ((z * p) >> 30) / 64'd11;
		p = ONE30 - ((z * p) >> 30) / 64'd10;
		p = ONE30 - ((z * p) >> 30) / 64'd9;
		p = ONE30 - ((z * p) >> 30) / 64'd8;
		p = ONE30 - ((z * p) >> 30) / 64'd7;
		p = ONE30 - ((z * p) >> 30) / 64'd6;
		p = ONE30 - ((z * p) >> 30) / 64'd5;
		p = ONE30 - ((z * p) >> 30) / 64'd4;
		p = ONE30 - ((z * p) >> 30) / 64'd3;
		p = ONE30 - ((z * p) >> 30) / 64'd2;
		p = ONE30 - ((z * p) >> 30);
		p = (p * p + (64'd1 << 29)) >> 30;
		p = (p * p + (64'd1 << 29)) >> 30;
		p = (p * p + (64'd1 << 29)) >> 30;
		return p;
	endfunction

	function automatic sin_rom_t build_sin_rom();
		sin_rom_t    rom;
		logic [63:0] q, r, v;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			q = (64'(4 * k)) / 64'(TABLE_DEPTH);
			r = 64'(4 * k) - q * 64'(TABLE_DEPTH);
			v = q[0] ? quarter_sine(64'(TABLE_DEPTH) - r) : quarter_sine(r);
			rom[k] = (q >= 64'd2) ? SIN_W'(-v) : SIN_W'(v);
		end
		return rom;
	endfunction

	localparam sin_rom_t SIN_ROM = build_sin_rom();
	localparam logic [63:0] EASE_DEN = ONE30 - neg_exp_q30(64'(TABLE_DEPTH));

	function automatic ease_rom_t build_ease_rom();
		ease_rom_t   rom;
		logic [63:0] num;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			num    = (ONE30 - neg_exp_q30(64'(k))) << 16;
			rom[k] = SIN_W'((num + (EASE_DEN >> 1)) / EASE_DEN);
		end
		return rom;
	endfunction

	localparam ease_rom_t EASE_ROM = build_ease_rom();

endpackage

### rtl/fti_lookup.sv
// Sine, cosine and ease-curve lookup with linear interpolation, two register stages.
// Depends on fti_pkg for the constant ROM tables and widths.
module fti_lookup (
	input  logic                              clk,
	input  logic [16:0]                       angle,
	input  logic [16:0]                       t,
	output logic signed [fti_pkg::SIN_W-1:0]  sin_val,
	output logic signed [fti_pkg::SIN_W-1:0]  cos_val,
	output logic signed [fti_pkg::SIN_W-1:0]  ease_val
);
	import fti_pkg::*;

	logic [15:0]            us, uc;
	logic [POS_W-1:0]       pos_s, pos_c, pos_e;
	logic [TABLE_BITS-1:0]  si_idx, si_nxt, co_idx, co_nxt;
	logic [EASE_IDX_W-1:0]  ea_raw, ea_idx, ea_nxt;

	logic signed [SIN_W-1:0] sa_s3, ca_s3, ea_s3;
	logic signed [SIN_W:0]   sd_s3, cd_s3, ed_s3;
	logic [15:0]             sf_s3, cf_s3, ef_s3;
	logic signed [SIN_W-1:0] sin_s4, cos_s4, ease_s4;

	function automatic logic [TABLE_BITS-1:0] wrap_next(input logic [TABLE_BITS-1:0] i);
		logic [TABLE_BITS:0] inc;
		inc = {1'b0, i} + 1'b1;
		return (inc >= (TABLE_BITS+1)'(TABLE_DEPTH)) ? '0 : inc[TABLE_BITS-1:0];
	endfunction

	function automatic logic signed [SIN_W-1:0] interp(input logic signed [SIN_W-1:0] a,
			input logic signed [SIN_W:0] dl, input logic [15:0] fr);
		logic signed [SIN_W+17:0] pr;
		pr = (SIN_W+18)'(dl) * (SIN_W+18)'($signed({1'b0, fr}));
		return a + $signed(pr[SIN_W+15:16]);
	endfunction

	always_comb begin
		us     = angle[15:0];
		uc     = angle[15:0] + QUARTER_TURN;
		pos_s  = POS_W'(us) * POS_W'(TABLE_DEPTH);
		pos_c  = POS_W'(uc) * POS_W'(TABLE_DEPTH);
		pos_e  = POS_W'(t) * POS_W'(TABLE_DEPTH);
		si_idx = pos_s[16 +: TABLE_BITS];
		co_idx = pos_c[16 +: TABLE_BITS];
		si_nxt = wrap_next(si_idx);
		co_nxt = wrap_next(co_idx);
		ea_raw = pos_e[16 +: EASE_IDX_W];
		// clamp at the last entry, which has no right neighbor
		ea_idx = (ea_raw > EASE_IDX_W'(TABLE_DEPTH)) ? EASE_IDX_W'(TABLE_DEPTH) : ea_raw;
		ea_nxt = (ea_idx < EASE_IDX_W'(TABLE_DEPTH)) ? ea_idx + 1'b1 : ea_idx;
	end

	always_ff @(posedge clk) begin
		sa_s3   <= SIN_ROM[si_idx];
		sd_s3   <= (SIN_W+1)'(SIN_ROM[si_nxt]) - (SIN_W+1)'(SIN_ROM[si_idx]);
		sf_s3   <= pos_s[15:0];
		ca_s3   <= SIN_ROM[co_idx];
		cd_s3   <= (SIN_W+1)'(SIN_ROM[co_nxt]) - (SIN_W+1)'(SIN_ROM[co_idx]);
		cf_s3   <= pos_c[15:0];
		ea_s3   <= EASE_ROM[ea_idx];
		ed_s3   <= (SIN_W+1)'(EASE_ROM[ea_nxt]) - (SIN_W+1)'(EASE_ROM[ea_idx]);
		ef_s3   <= pos_e[15:0];
		sin_s4  <= interp(sa_s3, sd_s3, sf_s3);
		cos_s4  <= interp(ca_s3, cd_s3, cf_s3);
		ease_s4 <= interp(ea_s3, ed_s3, ef_s3);
	end

	assign sin_val  = sin_s4;
	assign cos_val  = cos_s4;
	assign ease_val = ease_s4;

endmodule

### rtl/foot_trajectory_interpolator.sv
// Foot trajectory interpolator: seven-stage pipeline from request to foot position.
// An accepted transaction passes through stage registers s1 to s7 and is on result, with
// done high, once it reaches s7. Throughput: one transaction per cycle; busy is never
// asserted. Reset clears the valid pipeline and loads the height registers with their
// defaults; the ROM tables are constants.
// Depends on fti_pkg and fti_lookup.
module foot_trajectory_interpolator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  fti_pkg::req_t                   req,
	output logic                            done,
	output fti_pkg::rsp_t                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fti_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import fti_pkg::*;

	logic [11:0] swing_q, lift_q, arc_q;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1
	logic [PHASE_BITS:0] p_sat;
	logic [16:0]         t_in;
	logic [2:0]          op_s1;
	pts_t                pts_s1;
	logic [16:0]         t_s1;

	// stage 2
	logic [20:0]        t10;
	logic [20:0]        dnum;
	logic [40:0]        s_prod, d_prod;
	logic signed [18:0] q;
	logic signed [37:0] sq;
	logic [18:0]        t3;
	logic [16:0]        w3;
	logic [1:0]         seg;
	logic [2:0]         op_s2;
	pts_t               pts_s2;
	logic [16:0]        t_s2, s_s2, d_s2, q2_s2, w3_s2;
	logic               rise_s2;
	logic [1:0]         seg_s2;

	// stage 3
	logic [16:0]        angle;
	logic [28:0]        arc_p;
	logic [25:0]        gy_p, gz_p, fz_p;
	logic [16:0]        drem;
	logic [15:0]        ey, ez;
	logic [2:0]         op_s3;
	pts_t               pts_s3;
	logic [16:0]        u_s3, q2_s3, w3_s3;
	logic               rise_s3;
	logic [1:0]         seg_s3;
	logic [15:0]        ey_s3, ez_s3;

	// stage 4
	logic signed [SIN_W-1:0] sin_val, cos_val, ease_val;
	logic [2:0]         op_s4;
	pts_t               pts_s4;
	logic [16:0]        u_s4, q2_s4, w3_s4;
	logic               rise_s4;
	logic [1:0]         seg_s4;
	logic [15:0]        ey_s4, ez_s4;

	// stage 5
	logic signed [33:0] sp;
	logic signed [18:0] f, hm;
	logic [2:0]         op_s5;
	pts_t               pts_s5;
	logic [16:0]        u_s5, q2_s5, w3_s5, hv_s5;
	logic               rise_s5;
	logic [1:0]         seg_s5;
	logic [15:0]        ey_s5, ez_s5;
	logic signed [18:0] f_s5;
	logic signed [SIN_W-1:0] ease_s5;

	// stage 6
	logic signed [17:0] dx, dy, dz, ddrop;
	logic signed [18:0] wu, whv, wt3, wpar, wease;
	logic [17:0]        qsum;
	logic signed [15:0] bx, by, bz, szh;
	logic signed [17:0] dxs, dys, dzs;
	logic signed [18:0] wx, wy, wz;
	logic               half;
	logic signed [36:0] px, py, pz;
	logic signed [15:0] bx_s6, by_s6, bz_s6, mx_s6, my_s6;
	logic [16:0]        mz_s6;
	logic               half_s6;
	logic [15:0]        ey_s6, ez_s6;

	// stage 7
	logic [15:0] mz;
	rsp_t        rsp_s7;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign done   = v_s7;
	assign result = rsp_s7;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swing_q <= SWING_RESET;
			lift_q  <= LIFT_RESET;
			arc_q   <= ARC_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[CFG_ADDR_W-1:2])
				REG_SWING: swing_q <= pwdata[11:0];
				REG_LIFT:  lift_q  <= pwdata[11:0];
				REG_ARC:   arc_q   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[CFG_ADDR_W-1:2])
			REG_SWING: prdata = {20'd0, swing_q};
			REG_LIFT:  prdata = {20'd0, lift_q};
			REG_ARC:   prdata = {20'd0, arc_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: saturate phase and rescale to Q16
	always_comb begin
		p_sat = (req.phase > PHASE_ONE) ? PHASE_ONE : req.phase;
		t_in  = 17'({p_sat, 16'd0} >> PHASE_BITS);
	end

	always_ff @(posedge clk) begin
		op_s1  <= req.operation;
		pts_s1 <= '{req.start_x, req.start_y, req.start_z,
		           req.target_x, req.target_y, req.target_z};
		t_s1   <= t_in;
	end

	// stage 2: gap rise/fall phases, parabola square, three-segment split
	always_comb begin
		t10    = 21'(t_s1) * 21'd10;
		s_prod = 41'(t_s1) * 41'(GAP_S_MUL);
		dnum   = t10 - 21'(GAP_RISE_END);
		d_prod = 41'(dnum[18:0]) * 41'(DIV7_MUL);
		q      = $signed({1'b0, t_s1, 1'b0}) - 19'sd65536;
		sq     = 38'(q) * 38'(q);
		t3     = 19'(t_s1) * 19'd3;
		if (t3 <= 19'(Q16_ONE)) begin
			seg = SEG_LIFT;
			w3  = 17'(t3);
		end else if (t3 <= 19'(2 * Q16_ONE)) begin
			seg = SEG_MOVE;
			w3  = 17'(t3 - 19'(Q16_ONE));
		end else begin
			seg = SEG_DROP;
			w3  = 17'(t3 - 19'(2 * Q16_ONE));
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		pts_s2  <= pts_s1;
		t_s2    <= t_s1;
		s_s2    <= s_prod[37:21];
		d_s2    <= d_prod[38:22];
		rise_s2 <= t10 <= 21'(GAP_RISE_END);
		q2_s2   <= sq[32:16];
		w3_s2   <= w3;
		seg_s2  <= seg;
	end

	// stage 3: table lookups start, fixed offsets for parabola and gap
	always_comb begin
		angle = (op_s2 == OP_GAP) ? d_s2 : t_s2;
		arc_p = 29'(arc_q) * 29'(q2_s2);
		gy_p  = 26'(s_s2) * 26'(GAP_SIDE);
		gz_p  = 26'(s_s2) * 26'(GAP_RISE);
		drem  = 17'(Q16_ONE) - d_s2;
		fz_p  = 26'(drem) * 26'(GAP_RISE);
		ey    = '0;
		ez    = '0;
		case (op_s2)
			OP_PARABOLIC: ez = 16'(arc_q) - 16'(arc_p[27:16]);
			OP_GAP: begin
				if (rise_s2) begin
					ey = 16'd0 - 16'(gy_p[24:16]);
					ez = 16'(gz_p[24:16]);
				end else begin
					ey = 16'd0 - 16'(GAP_SIDE);
					ez = 16'(fz_p[24:16]);
				end
			end
			default: ;
		endcase
	end

	fti_lookup u_lookup (
		.clk      (clk),
		.angle    (angle),
		.t        (t_s2),
		.sin_val  (sin_val),
		.cos_val  (cos_val),
		.ease_val (ease_val)
	);

	always_ff @(posedge clk) begin
		op_s3   <= op_s2;
		pts_s3  <= pts_s2;
		u_s3    <= angle;
		q2_s3   <= q2_s2;
		w3_s3   <= w3_s2;
		rise_s3 <= rise_s2;
		seg_s3  <= seg_s2;
		ey_s3   <= ey;
		ez_s3   <= ez;
	end

	// stage 4: interpolation runs inside the lookup
	always_ff @(posedge clk) begin
		op_s4   <= op_s3;
		pts_s4  <= pts_s3;
		u_s4    <= u_s3;
		q2_s4   <= q2_s3;
		w3_s4   <= w3_s3;
		rise_s4 <= rise_s3;
		seg_s4  <= seg_s3;
		ey_s4   <= ey_s3;
		ez_s4   <= ez_s3;
	end

	// stage 5: cycloid fraction and half versine
	always_comb begin
		sp = 34'(sin_val) * 34'(INV_TWO_PI_Q16);
		f  = $signed({2'b00, u_s4}) - $signed(sp[33:16]);
		hm = 19'sd65536 - 19'(cos_val);
	end

	always_ff @(posedge clk) begin
		op_s5   <= op_s4;
		pts_s5  <= pts_s4;
		u_s5    <= u_s4;
		q2_s5   <= q2_s4;
		w3_s5   <= w3_s4;
		rise_s5 <= rise_s4;
		seg_s5  <= seg_s4;
		ey_s5   <= ey_s4;
		ez_s5   <= ez_s4;
		f_s5    <= f;
		hv_s5   <= hm[17:1];
		ease_s5 <= ease_val;
	end

	// stage 6: pick base, span and weight per axis, then multiply
	always_comb begin
		dx    = 18'(pts_s5.gx) - 18'(pts_s5.sx);
		dy    = 18'(pts_s5.gy) - 18'(pts_s5.sy);
		dz    = 18'(pts_s5.gz) - 18'(pts_s5.sz);
		ddrop = dz - $signed({6'd0, lift_q});
		szh   = pts_s5.sz + $signed({4'd0, lift_q});
		qsum  = 18'(q2_s5) + 18'(Q16_ONE);
		wu    = $signed({2'b00, u_s5});
		whv   = $signed({2'b00, hv_s5});
		wt3   = $signed({2'b00, w3_s5});
		wpar  = $signed({1'b0, qsum});
		wease = 19'(ease_s5);

		bx   = pts_s5.sx;
		by   = pts_s5.sy;
		bz   = pts_s5.sz;
		dxs  = '0;
		dys  = '0;
		dzs  = '0;
		wx   = '0;
		wy   = '0;
		wz   = '0;
		half = 1'b0;
		case (op_s5)
			OP_LINEAR: begin
				dxs = dx;
				dys = dy;
				dzs = dz;
				wx  = wu;
				wy  = wu;
				wz  = wu;
			end
			OP_CYCLOID: begin
				dxs = dx;
				dys = dy;
				wx  = f_s5;
				wy  = f_s5;
				dzs = $signed({6'd0, swing_q});
				wz  = whv;
			end
			OP_THREE_SEG: begin
				case (seg_s5)
					SEG_LIFT: begin
						dzs = $signed({6'd0, lift_q});
						wz  = wt3;
					end
					SEG_MOVE: begin
						dxs = dx;
						dys = dy;
						wx  = wt3;
						wy  = wt3;
						bz  = szh;
					end
					SEG_DROP: begin
						bx  = pts_s5.gx;
						by  = pts_s5.gy;
						bz  = szh;
						dzs = ddrop;
						wz  = wt3;
					end
					default: ;
				endcase
			end
			OP_PARABOLIC: begin
				dxs  = dx;
				dys  = dy;
				dzs  = dz;
				wx   = wu;
				wy   = wu;
				wz   = wpar;
				half = 1'b1;
			end
			OP_EASE: begin
				dxs = dx;
				dys = dy;
				dzs = dz;
				wx  = wease;
				wy  = wease;
				wz  = wease;
			end
			OP_GAP: begin
				// the rise leg is all offsets; the swing leg mixes like the cycloid
				if (!rise_s5) begin
					dxs = dx;
					dys = dy;
					wx  = f_s5;
					wy  = f_s5;
					bz  = pts_s5.gz;
					dzs = 18'(GAP_ARC);
					wz  = whv;
				end
			end
			default: ;
		endcase
		px = 37'(dxs) * 37'(wx);
		py = 37'(dys) * 37'(wy);
		pz = 37'(dzs) * 37'(wz);
	end

	always_ff @(posedge clk) begin
		bx_s6   <= bx;
		by_s6   <= by;
		bz_s6   <= bz;
		mx_s6   <= px[31:16];
		my_s6   <= py[31:16];
		mz_s6   <= pz[32:16];
		half_s6 <= half;
		ey_s6   <= ey_s5;
		ez_s6   <= ez_s5;
	end

	// stage 7: sum and wrap to 16 bits
	always_comb begin
		mz = half_s6 ? mz_s6[16:1] : mz_s6[15:0];
	end

	always_ff @(posedge clk) begin
		rsp_s7.foot_x <= bx_s6 + mx_s6;
		rsp_s7.foot_y <= by_s6 + my_s6 + $signed(ey_s6);
		rsp_s7.foot_z <= bz_s6 + $signed(mz) + $signed(ez_s6);
	end

endmodule
